[rtl/xs1024_pkg.sv]
// Package for the xorshift1024* generator: field widths, scheme constants,
// item kind codes and the pipeline stage record. No dependencies.
`timescale 1ns / 1ps

package xs1024_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned Words   = 16;
  localparam int unsigned InDataW = 72;  // index + word, padded to whole bytes

  localparam int unsigned ShiftA = 31;
  localparam int unsigned ShiftB = 11;
  localparam int unsigned ShiftC = 30;

  localparam logic [63:0] Mult   = 64'd1181783497276652981;
  localparam logic [31:0] MultLo = Mult[31:0];
  localparam logic [31:0] MultHi = Mult[63:32];

  typedef enum logic [0:0] {
    FUNC_SEED = 1'b0,
    FUNC_GEN  = 1'b1
  } func_e;

  // Item in the read/modify stage, next to the registered memory data.
  typedef struct packed {
    func_e             func;
    logic [IdxW-1:0]   wr_addr;   // seed index, or the advanced position
    logic [WordW-1:0]  seed_word;
    logic              fwd_a;     // word at position was written on the read edge
    logic              fwd_b;     // word after position was written on the read edge
    logic              vld_a;     // word at position has been written since reset
    logic              vld_b;
  } s1_t;

endpackage

[rtl/xorshift1024_star_generator_unit.sv]
// xorshift1024* generator: state ring in a two-read-port memory, xorshift
// update with write-back forwarding, and a split constant multiply.
// Depends on xs1024_pkg.
`timescale 1ns / 1ps

// Channel   | Dir | tdata (low bit up)                   | tuser
// ----------+-----+--------------------------------------+----------------------
// s_axis    | in  | seed_index[3:0], seed_word[67:4], 0s | func (0 seed, 1 gen)
// m_axis    | out | random_value[63:0]                   | -
//
// One item per cycle sustained while m_axis is not stalled. A generate beat
// passes through the memory read on the accepting edge, then xorshift and
// write-back, partial products and the final sum; the memory read-modify-write
// loop is closed by forwarding the written word to the reads on the same edge.
// Seed beats write one state word and give no result.
// Reset (rst_ni low) clears the position, the pipeline and a valid bit per
// state word; an unwritten word reads as zero, so no clearing pass is needed.
// Each stage advances when the next one is empty or advancing, so bubbles
// collapse and input is taken while a result waits on m_axis if a stage is free.

module xorshift1024_star_generator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [3:0] seed_index, [67:4] seed_word, [71:68] zero
  input  logic [xs1024_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] func
  input  logic                            s_axis_tuser_i,

  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [63:0] random_value
  output logic [xs1024_pkg::WordW-1:0]    m_axis_tdata_o
);

  import xs1024_pkg::*;

  // State ring and per-word written flags
  logic [WordW-1:0] mem_q [Words];
  logic [Words-1:0] vld_q;

  logic [IdxW-1:0]  pos_q, pos_d;

  // Stage 1: registered read data plus the item
  logic             s1_v_q;
  s1_t              s1_q;
  logic [WordW-1:0] rd_a_q, rd_b_q;

  // Stage 2: new state word; stage 3: partial products; stage 4: output
  logic             s2_v_q, s3_v_q, s4_v_q;
  logic [WordW-1:0] s2_word_q;
  logic [WordW-1:0] s3_ll_q;
  logic [31:0]      s3_lh_q, s3_hl_q;
  logic [WordW-1:0] s4_out_q;

  logic             adv1, adv2, adv3, adv4;
  logic             in_acc;
  func_e            in_func;
  logic [IdxW-1:0]  in_idx;
  logic [WordW-1:0] in_word;
  logic [IdxW-1:0]  rd_addr_a, rd_addr_b;

  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  logic [WordW-1:0] wr_data;

  logic [WordW-1:0] w0, w1, t1, t2, new_word;
  logic [WordW-1:0] mul_ll;
  logic [31:0]      mul_lh, mul_hl;

  // Stage advance chain: a stage moves when the one after it is free
  assign adv4 = !s4_v_q || m_axis_tready_i;
  assign adv3 = !s3_v_q || adv4;
  assign adv2 = !s2_v_q || adv3;
  assign adv1 = !s1_v_q || adv2;

  assign s_axis_tready_o = adv1;
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_func = func_e'(s_axis_tuser_i);
  assign in_idx  = s_axis_tdata_i[IdxW-1:0];
  assign in_word = s_axis_tdata_i[IdxW +: WordW];

  // Generate reads the word at the position and the one after it
  assign rd_addr_a = pos_q;
  assign rd_addr_b = pos_q + 4'd1;

  always_comb begin
    pos_d = pos_q;
    if (in_acc) begin
      if (in_func == FUNC_SEED) begin
        pos_d = '0;
      end else begin
        pos_d = rd_addr_b;
      end
    end
  end

  // Stage 1 data with forwarding from the write on the read edge
  always_comb begin
    w0 = s1_q.fwd_a ? s2_word_q : (s1_q.vld_a ? rd_a_q : '0);
    w1 = s1_q.fwd_b ? s2_word_q : (s1_q.vld_b ? rd_b_q : '0);
    t1 = w1 ^ (w1 << ShiftA);
    t2 = t1 ^ (t1 >> ShiftB);
    new_word = w0 ^ (w0 >> ShiftC) ^ t2;
  end

  // Single write port: seeds and generated words both retire from stage 1
  assign wr_en   = s1_v_q && adv2;
  assign wr_addr = s1_q.wr_addr;
  assign wr_data = (s1_q.func == FUNC_SEED) ? s1_q.seed_word : new_word;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (in_acc) begin
      rd_a_q <= mem_q[rd_addr_a];
      rd_b_q <= mem_q[rd_addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      pos_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      pos_q <= pos_d;
      if (adv1) s1_v_q <= in_acc;
      if (adv2) s2_v_q <= s1_v_q && (s1_q.func == FUNC_GEN);
      if (adv3) s3_v_q <= s2_v_q;
      if (adv4) s4_v_q <= s3_v_q;
    end
  end

  // Payload registers: the item with forward and valid flags, written word, products, output
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.func      <= in_func;
      s1_q.wr_addr   <= (in_func == FUNC_SEED) ? in_idx : rd_addr_b;
      s1_q.seed_word <= in_word;
      s1_q.fwd_a     <= wr_en && (wr_addr == rd_addr_a);
      s1_q.fwd_b     <= wr_en && (wr_addr == rd_addr_b);
      s1_q.vld_a     <= vld_q[rd_addr_a];
      s1_q.vld_b     <= vld_q[rd_addr_b];
    end
    // Hold the written word: it also serves as the forwarding source
    if (wr_en) begin
      s2_word_q <= wr_data;
    end
    if (adv3) begin
      s3_ll_q <= mul_ll;
      s3_lh_q <= mul_lh;
      s3_hl_q <= mul_hl;
    end
    if (adv4) begin
      s4_out_q <= s3_ll_q + {s3_lh_q + s3_hl_q, 32'd0};
    end
  end

  // Low 64 bits of word * Mult from three 32x32 products
  assign mul_ll = 64'(s2_word_q[31:0]) * 64'(MultLo);
  assign mul_lh = s2_word_q[31:0] * MultHi;
  assign mul_hl = s2_word_q[63:32] * MultLo;

  assign m_axis_tvalid_o = s4_v_q;
  assign m_axis_tdata_o  = s4_out_q;

  // A seed beat rewinds the position
  a_seed_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_func == FUNC_SEED) |=> pos_q == '0)
    else $error("position not cleared after seed beat");

  // A generate beat advances the position by one
  a_gen_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_func == FUNC_GEN) |=> pos_q == $past(pos_q) + 4'd1)
    else $error("position not advanced after generate beat");

  // A generate item writes back at the advanced position
  a_gen_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_func == FUNC_GEN) |=> s1_v_q && (s1_q.wr_addr == pos_q))
    else $error("generate write-back address differs from position");

  // Only generate items reach the multiply stages
  a_no_seed_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && adv2 && (s1_q.func == FUNC_SEED) |=> !s2_v_q)
    else $error("seed item entered the result pipeline");

endmodule

[dv/tb_xorshift1024_star_generator_unit.sv]
// Testbench for xorshift1024_star_generator_unit: drives seed and generate beats, predicts
// each random value from its own copy of the state ring, and checks the output stream.
// Depends on xs1024_pkg and the generator RTL.
`timescale 1ns / 1ps

module tb_xorshift1024_star_generator_unit;
  import xs1024_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 12;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [WordW-1:0]    m_axis_tdata;

  // Shadow of the generator state
  logic [WordW-1:0] ring_words [Words];
  logic [IdxW-1:0]  ring_pos;
  logic [WordW-1:0] pending_randoms [$];

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned beats_sent = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  xorshift1024_star_generator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver backpressure, redrawn every cycle.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted output beat with the oldest predicted value.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_randoms.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected beat, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        if (m_axis_tdata !== pending_randoms[0]) begin
          fail_count++;
          $display("%0t: random_value mismatch, expected %h, actual %h",
                   $time, pending_randoms[0], m_axis_tdata);
        end
        void'(pending_randoms.pop_front());
      end
    end
  end

  // Apply one accepted beat to the shadow ring; a generate queues its random value.
  task automatic advance_ring(input func_e fn, input logic [IdxW-1:0] idx,
                              input logic [WordW-1:0] word);
    logic [WordW-1:0] w0;
    logic [WordW-1:0] w1;
    logic [WordW-1:0] fresh;
    logic [WordW-1:0] scrambled;
    if (fn == FUNC_SEED) begin
      ring_words[idx] = word;
      ring_pos = '0;
    end else begin
      w0 = ring_words[ring_pos];
      ring_pos = ring_pos + 1'b1;
      w1 = ring_words[ring_pos];
      w1 ^= w1 << ShiftA;
      w1 ^= w1 >> ShiftB;
      w0 ^= w0 >> ShiftC;
      fresh = w0 ^ w1;
      ring_words[ring_pos] = fresh;
      scrambled = fresh * Mult;
      pending_randoms.push_back(scrambled);
    end
  endtask

  // Send one beat, with random idle cycles ahead of it, and hold until accepted.
  task automatic send_beat(input func_e fn, input logic [IdxW-1:0] idx,
                           input logic [WordW-1:0] word);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {4'b0000, word, idx};
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    advance_ring(fn, idx, word);
    beats_sent++;
  endtask

  task automatic send_seed(input logic [IdxW-1:0] idx, input logic [WordW-1:0] word);
    send_beat(FUNC_SEED, idx, word);
  endtask

  // Index and word are don't-care on a generate; randomize them anyway.
  task automatic send_generate();
    send_beat(FUNC_GEN, IdxW'($urandom), {$urandom, $urandom});
  endtask

  function automatic logic [WordW-1:0] pick_seed_word();
    case ($urandom_range(7))
      0: return '1;
      1: return '0;
      2: return 64'd1 << $urandom_range(63);
      3: return ~(64'd1 << $urandom_range(63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic set_idling(input int unsigned gap, input int unsigned stall);
    gap_pct = gap;
    stall_pct = stall;
  endtask

  // Generate on the all-zero ring: outputs stay zero.
  task automatic test_unseeded();
    repeat (2) send_generate();
  endtask

  // Extreme words at the ends of the ring, then a full lap so the position wraps.
  task automatic test_extremes_and_wrap();
    send_seed(4'd0, '1);
    send_seed(4'd15, 64'd1);
    send_seed(4'd1, 64'h8000_0000_0000_0000);
    repeat (16) send_generate();
  endtask

  // A lone seed load mid-stream rewrites one word and sends the position back to zero.
  task automatic test_partial_reseed();
    send_seed(4'd5, {$urandom, $urandom});
    repeat (2) send_generate();
  endtask

  // Half full reseeds followed by generate bursts; else bursts, partial seeds and noise.
  task automatic test_random_traffic(input int unsigned n_beats);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned order [Words];
    int unsigned j;
    int unsigned tmp;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        for (int k = 0; k < Words; k++) order[k] = k;
        case ($urandom_range(2))
          0: ;
          1: for (int k = 0; k < Words; k++) order[k] = Words - 1 - k;
          default: begin
            for (int k = Words - 1; k > 0; k--) begin
              j = $urandom_range(k);
              tmp = order[k];
              order[k] = order[j];
              order[j] = tmp;
            end
          end
        endcase
        for (int k = 0; k < Words; k++) send_seed(IdxW'(order[k]), pick_seed_word());
        repeat ($urandom_range(40, 8)) send_generate();
      end else if (pick < 78) begin
        repeat ($urandom_range(30, 1)) send_generate();
      end else if (pick < 92) begin
        send_seed(IdxW'($urandom), pick_seed_word());
        repeat ($urandom_range(6)) send_generate();
      end else begin
        repeat ($urandom_range(6, 1)) begin
          send_beat(func_e'($urandom_range(1)), IdxW'($urandom), {$urandom, $urandom});
        end
      end
    end
  endtask

  initial begin
    for (int k = 0; k < Words; k++) ring_words[k] = '0;
    ring_pos = '0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_idling(0, 0);
    test_unseeded();
    test_extremes_and_wrap();
    test_partial_reseed();

    set_idling(0, 0);
    test_random_traffic(440);
    set_idling(63, 0);
    test_random_traffic(440);
    set_idling(0, 63);
    test_random_traffic(440);
    set_idling(12, 12);
    test_random_traffic(440);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (pending_randoms.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (pending_randoms.size() != 0) begin
      fail_count++;
      $display("%0t: %0d random values never arrived, expected %h, actual none",
               $time, pending_randoms.size(), pending_randoms[0]);
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/xs1024_pkg.sv
rtl/xorshift1024_star_generator_unit.sv
dv/tb_xorshift1024_star_generator_unit.sv
